// ----- hdl/fhpa_pkg.sv -----
// Handle pool allocator: shared types, codes and widths.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fhpa_pkg;

   localparam int HANDLE_W     = 8;
   localparam int COUNT_W      = 9;
   localparam int HANDLE_SPACE = 256;

   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [1:0]          func_type;
   typedef logic [1:0]          status_type;

   localparam func_type FUNC_ALLOC = 2'd0;
   localparam func_type FUNC_TRY   = 2'd1;
   localparam func_type FUNC_FREE  = 2'd2;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NONE_FREE = 2'd1;
   localparam status_type STATUS_INVALID   = 2'd2;
   localparam status_type STATUS_EXHAUSTED = 2'd3;

   typedef struct packed {
      func_type   func;
      handle_type handle_in;
   } req_type;

   typedef struct packed {
      handle_type handle_out;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic       wr_en;
      handle_type wr_addr;
      handle_type wr_data;
      handle_type rd_addr;
   } fifo_port_type;

   typedef struct packed {
      logic       wr_en;
      handle_type wr_addr;
      logic       wr_bit;
      handle_type rd_addr;
   } map_port_type;

endpackage

`default_nettype wire

// ----- hdl/fhpa_free_fifo.sv -----
// Free-handle queue storage: one write port, one registered read port.
// Depends on fhpa_pkg.
`default_nettype none

module fhpa_free_fifo (
   input  wire logic                    clock,
   input  wire fhpa_pkg::fifo_port_type fifo_ctl,
   output      fhpa_pkg::handle_type    rd_data
);

   fhpa_pkg::handle_type mem [fhpa_pkg::HANDLE_SPACE];
   fhpa_pkg::handle_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (fifo_ctl.wr_en) begin
         mem[fifo_ctl.wr_addr] <= fifo_ctl.wr_data;
      end
      rd_data_ff <= mem[fifo_ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/fhpa_alloc_map.sv -----
// Allocated-handle bitmap: single-bit memory with per-entry valid flags
// cleared at reset. Registered read. Depends on fhpa_pkg.
`default_nettype none

module fhpa_alloc_map (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fhpa_pkg::map_port_type map_ctl,
   output      logic                   rd_bit
);

   logic                             mem [fhpa_pkg::HANDLE_SPACE];
   logic [fhpa_pkg::HANDLE_SPACE-1:0] valid_ff;
   logic                             mem_q_ff;
   logic                             valid_q_ff;

   always_ff @(posedge clock) begin
      if (map_ctl.wr_en) begin
         mem[map_ctl.wr_addr] <= map_ctl.wr_bit;
      end
      mem_q_ff <= mem[map_ctl.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         valid_q_ff <= 1'b0;
      end else begin
         if (map_ctl.wr_en) begin
            valid_ff[map_ctl.wr_addr] <= 1'b1;
         end
         valid_q_ff <= valid_ff[map_ctl.rd_addr];
      end
   end

   assign rd_bit = valid_q_ff & mem_q_ff;

endmodule

`default_nettype wire

// ----- hdl/fhpa_ctrl.sv -----
// Request sequencer: pointers, counters, read-modify-write of both memories
// and the result register. Depends on fhpa_pkg.
`default_nettype none

module fhpa_ctrl #(
   parameter int POOL_SIZE = 256
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire fhpa_pkg::req_type       req_data,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      fhpa_pkg::rsp_type       rsp_data,
   output      fhpa_pkg::fifo_port_type fifo_ctl,
   input  wire fhpa_pkg::handle_type    fifo_rd_data,
   output      fhpa_pkg::map_port_type  map_ctl,
   input  wire logic                    map_rd_bit
);

   localparam int CAP = (POOL_SIZE < fhpa_pkg::HANDLE_SPACE) ?
                        POOL_SIZE : fhpa_pkg::HANDLE_SPACE;
   localparam fhpa_pkg::count_type  CAP_COUNT = fhpa_pkg::count_type'(CAP);
   localparam fhpa_pkg::handle_type PTR_LAST  = fhpa_pkg::handle_type'(CAP - 1);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type            state_ff, state_in;
   fhpa_pkg::req_type    req_ff, req_in;
   fhpa_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   fhpa_pkg::handle_type head_ff, head_in;
   fhpa_pkg::handle_type tail_ff, tail_in;
   fhpa_pkg::count_type  free_count_ff, free_count_in;
   fhpa_pkg::count_type  created_ff, created_in;

   logic                   accept;
   logic                   fire;
   logic                   map_we;
   logic                   map_wbit;
   fhpa_pkg::handle_type   map_waddr;
   logic                   fifo_we;
   fhpa_pkg::handle_type   grant_h;
   fhpa_pkg::status_type   status_v;

   assign accept    = (state_ff == S_IDLE) && req_valid;
   assign fire      = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_count_in = free_count_ff;
      created_in    = created_ff;
      grant_h       = '0;
      status_v      = fhpa_pkg::STATUS_INVALID;
      map_we        = 1'b0;
      map_wbit      = 1'b0;
      map_waddr     = req_ff.handle_in;
      fifo_we       = 1'b0;

      unique case (req_ff.func) inside
         fhpa_pkg::FUNC_ALLOC, fhpa_pkg::FUNC_TRY: begin
            if (free_count_ff != '0) begin
               grant_h       = fifo_rd_data;
               head_in       = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
               free_count_in = free_count_ff - 1'b1;
               map_we        = 1'b1;
               map_wbit      = 1'b1;
               map_waddr     = fifo_rd_data;
               status_v      = fhpa_pkg::STATUS_OK;
            end else if (req_ff.func == fhpa_pkg::FUNC_TRY) begin
               status_v = fhpa_pkg::STATUS_NONE_FREE;
            end else if (created_ff < CAP_COUNT) begin
               grant_h    = created_ff[fhpa_pkg::HANDLE_W-1:0];
               created_in = created_ff + 1'b1;
               map_we     = 1'b1;
               map_wbit   = 1'b1;
               map_waddr  = created_ff[fhpa_pkg::HANDLE_W-1:0];
               status_v   = fhpa_pkg::STATUS_OK;
            end else begin
               status_v = fhpa_pkg::STATUS_EXHAUSTED;
            end
         end
         fhpa_pkg::FUNC_FREE: begin
            if ({1'b0, req_ff.handle_in} < CAP_COUNT && map_rd_bit) begin
               map_we        = 1'b1;
               map_wbit      = 1'b0;
               fifo_we       = 1'b1;
               tail_in       = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
               free_count_in = free_count_ff + 1'b1;
               status_v      = fhpa_pkg::STATUS_OK;
            end
         end
         default: begin
            status_v = fhpa_pkg::STATUS_INVALID;
         end
      endcase

      if (status_v != fhpa_pkg::STATUS_OK || req_ff.func == fhpa_pkg::FUNC_FREE) begin
         grant_h = '0;
      end

      if (!fire) begin
         head_in       = head_ff;
         tail_in       = tail_ff;
         free_count_in = free_count_ff;
         created_in    = created_ff;
      end

      rsp_in       = fire ? fhpa_pkg::rsp_type'{handle_out: grant_h, status: status_v}
                          : rsp_ff;
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
      req_in       = accept ? req_data : req_ff;

      unique case (state_ff)
         S_IDLE:  state_in = accept ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = fire ? S_IDLE : S_EXEC;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      fifo_ctl.wr_en   = fire && fifo_we;
      fifo_ctl.wr_addr = tail_ff;
      fifo_ctl.wr_data = req_ff.handle_in;
      fifo_ctl.rd_addr = head_ff;
      map_ctl.wr_en    = fire && map_we;
      map_ctl.wr_addr  = map_waddr;
      map_ctl.wr_bit   = map_wbit;
      map_ctl.rd_addr  = (state_ff == S_IDLE) ? req_data.handle_in : req_ff.handle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_count_ff <= '0;
         created_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_count_ff <= free_count_in;
         created_ff    <= created_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ----- hdl/fifo_handle_pool_allocator_top.sv -----
// Handle pool allocator, top level.
// Instantiates fhpa_ctrl, fhpa_free_fifo and fhpa_alloc_map; uses fhpa_pkg.
//
// Request channel (req_): func selects allocate, try-allocate or deallocate;
// handle_in is the handle being returned. Result channel (rsp_): handle_out
// and status, exactly one result transfer per request transfer, in order.
// Allocate takes the oldest freed handle, else creates a new one until
// min(POOL_SIZE, 256) handles exist. Try-allocate never creates a handle.
// Deallocate accepts only a currently allocated handle.
// The request is captured in a register, the free queue and bitmap memories
// are read, and S_EXEC updates them, writes back and loads the result register.
// The block takes no new request while one is in S_EXEC: req_stall is high outside S_IDLE.
// The result register lets the next request transfer while a result waits.
// Reset: synchronous; clears pointers, counts and the bitmap valid flags.
// No request is lost when rsp_stall is held: the result holds, and the
// block takes at most one further request before stalling.
`default_nettype none

module fifo_handle_pool_allocator_top #(
   parameter int POOL_SIZE = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire fhpa_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      fhpa_pkg::rsp_type rsp_data
);

   fhpa_pkg::fifo_port_type fifo_ctl;
   fhpa_pkg::map_port_type  map_ctl;
   fhpa_pkg::handle_type    fifo_rd_data;
   logic                    map_rd_bit;

   fhpa_ctrl #(
      .POOL_SIZE(POOL_SIZE)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fifo_ctl    (fifo_ctl),
      .fifo_rd_data(fifo_rd_data),
      .map_ctl     (map_ctl),
      .map_rd_bit  (map_rd_bit)
   );

   fhpa_free_fifo u_free_fifo (
      .clock   (clock),
      .fifo_ctl(fifo_ctl),
      .rd_data (fifo_rd_data)
   );

   fhpa_alloc_map u_alloc_map (
      .clock  (clock),
      .reset  (reset),
      .map_ctl(map_ctl),
      .rd_bit (map_rd_bit)
   );

endmodule

`default_nettype wire

// ----- hdl/fhpa_checker.sv -----
// Port-level checks for the handle pool allocator, bound to the top level.
// Depends on fhpa_pkg and fifo_handle_pool_allocator_top.
`default_nettype none

module fhpa_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire fhpa_pkg::rsp_type rsp_data
);

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_fail_no_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != fhpa_pkg::STATUS_OK |-> rsp_data.handle_out == '0)
      else $error("failed request carries a handle");

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("second request taken while one is in progress");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_xfer, 2))
      else $error("result without a matching request transfer");

endmodule

bind fifo_handle_pool_allocator_top fhpa_checker u_fhpa_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

`default_nettype wire

// ----- tb/sv/fifo_handle_pool_allocator_top_test.sv -----
// Testbench for fifo_handle_pool_allocator_top: directed and random allocate, try and
// free traffic with random idling on both channels, checked against a handle pool model.
// Depends on fhpa_pkg and the fifo_handle_pool_allocator_top RTL.
`timescale 1ns / 100ps

class pool_scoreboard;
   fhpa_pkg::handle_type free_q[$];
   fhpa_pkg::handle_type live_q[$];
   fhpa_pkg::rsp_type    pending_rsp_q[$];
   bit                   granted[fhpa_pkg::HANDLE_SPACE];
   int unsigned          created;
   int unsigned          pool_cap;
   int unsigned          fails;

   function new(int unsigned pool_size);
      pool_cap = (pool_size < fhpa_pkg::HANDLE_SPACE) ? pool_size : fhpa_pkg::HANDLE_SPACE;
      created  = 0;
      fails    = 0;
      foreach (granted[i]) granted[i] = 1'b0;
   endfunction

   function int unsigned pending();
      return pending_rsp_q.size();
   endfunction

   function fhpa_pkg::handle_type pick_live();
      return live_q[$urandom_range(0, live_q.size() - 1)];
   endfunction

   function void grant_handle(fhpa_pkg::handle_type h, ref fhpa_pkg::rsp_type r);
      granted[h] = 1'b1;
      live_q.push_back(h);
      r.handle_out = h;
      r.status     = fhpa_pkg::STATUS_OK;
   endfunction

   function void note_request(fhpa_pkg::req_type req);
      fhpa_pkg::rsp_type r;
      int                idx;
      r.handle_out = '0;
      r.status     = fhpa_pkg::STATUS_OK;
      case (req.func) inside
         fhpa_pkg::FUNC_ALLOC, fhpa_pkg::FUNC_TRY: begin
            if (free_q.size() > 0) begin
               grant_handle(free_q.pop_front(), r);
            end else if (req.func == fhpa_pkg::FUNC_TRY) begin
               r.status = fhpa_pkg::STATUS_NONE_FREE;
            end else if (created < pool_cap) begin
               grant_handle(fhpa_pkg::handle_type'(created), r);
               created++;
            end else begin
               r.status = fhpa_pkg::STATUS_EXHAUSTED;
            end
         end
         fhpa_pkg::FUNC_FREE: begin
            if (req.handle_in >= pool_cap || !granted[req.handle_in]) begin
               r.status = fhpa_pkg::STATUS_INVALID;
            end else begin
               granted[req.handle_in] = 1'b0;
               idx = -1;
               foreach (live_q[i]) if (live_q[i] == req.handle_in) idx = i;
               if (idx >= 0) live_q.delete(idx);
               free_q.push_back(req.handle_in);
            end
         end
         default: begin
            r.status = fhpa_pkg::STATUS_INVALID;
         end
      endcase
      pending_rsp_q.push_back(r);
   endfunction

   function void check_result(fhpa_pkg::rsp_type act);
      fhpa_pkg::rsp_type exp_rsp;
      if (pending_rsp_q.size() == 0) begin
         $error("unexpected result transfer: handle_out %0d, status %0d",
                act.handle_out, act.status);
         fails++;
         return;
      end
      exp_rsp = pending_rsp_q.pop_front();
      if (act.handle_out !== exp_rsp.handle_out) begin
         $error("handle_out: expected %0d, actual %0d", exp_rsp.handle_out, act.handle_out);
         fails++;
      end
      if (act.status !== exp_rsp.status) begin
         $error("status: expected %0d, actual %0d", exp_rsp.status, act.status);
         fails++;
      end
   endfunction
endclass

module fifo_handle_pool_allocator_top_test;

   localparam int                 POOL_SIZE    = 256;
   localparam int                 RANDOM_ITEMS = 1000;
   localparam int                 IDLE_LIMIT   = 2000;
   localparam int                 HOLD_CYCLES  = 300;
   localparam int                 HOLD_AT      = 400;
   localparam fhpa_pkg::func_type FUNC_UNUSED  = 2'd3;

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   fhpa_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   fhpa_pkg::rsp_type rsp_data;

   pool_scoreboard sb;
   int             sent_count   = 0;
   int             result_count = 0;
   int             idle_cycles  = 0;

   fifo_handle_pool_allocator_top #(
      .POOL_SIZE(POOL_SIZE)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_gap(int idx);
      if ((idx / 80) % 4 == 3) return 0;
      return $urandom_range(0, 6);
   endfunction

   task automatic send_request(fhpa_pkg::func_type f, fhpa_pkg::handle_type h);
      int                gap;
      fhpa_pkg::req_type req;
      gap = draw_gap(sent_count);
      req.func      = f;
      req.handle_in = h;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (req_stall);
      sb.note_request(req);
      sent_count++;
   endtask

   task automatic send_random(int idx);
      mix_type              mix;
      int                   roll;
      int                   t_alloc, t_try, t_live, t_any;
      fhpa_pkg::func_type   f;
      fhpa_pkg::handle_type h;
      if (idx < 400)      mix = MIX_GROW;
      else if (idx < 600) mix = MIX_SHRINK;
      else if (idx < 750) mix = MIX_GROW;
      else if (idx < 880) mix = MIX_SHRINK;
      else                mix = MIX_BALANCED;
      case (mix)
         MIX_GROW:   begin t_alloc = 80; t_try = 85; t_live = 93; t_any = 98; end
         MIX_SHRINK: begin t_alloc = 12; t_try = 20; t_live = 85; t_any = 95; end
         default:    begin t_alloc = 35; t_try = 50; t_live = 80; t_any = 95; end
      endcase
      roll = $urandom_range(0, 99);
      h    = fhpa_pkg::handle_type'($urandom_range(0, 255));
      if (roll < t_alloc) begin
         f = fhpa_pkg::FUNC_ALLOC;
      end else if (roll < t_try) begin
         f = fhpa_pkg::FUNC_TRY;
      end else if (roll < t_live) begin
         f = fhpa_pkg::FUNC_FREE;
         if (sb.live_q.size() > 0) h = sb.pick_live();
      end else if (roll < t_any) begin
         f = fhpa_pkg::FUNC_FREE;
      end else begin
         f = FUNC_UNUSED;
      end
      send_request(f, h);
   endtask

   initial begin
      sb = new(POOL_SIZE);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(fhpa_pkg::FUNC_TRY,   8'h00);
      send_request(fhpa_pkg::FUNC_FREE,  8'h00);
      send_request(FUNC_UNUSED,          8'h00);
      send_request(fhpa_pkg::FUNC_ALLOC, 8'hff);
      send_request(fhpa_pkg::FUNC_ALLOC, 8'h00);
      send_request(fhpa_pkg::FUNC_ALLOC, 8'haa);
      send_request(fhpa_pkg::FUNC_FREE,  8'h01);
      send_request(fhpa_pkg::FUNC_FREE,  8'h01);
      send_request(fhpa_pkg::FUNC_FREE,  8'hff);
      send_request(fhpa_pkg::FUNC_TRY,   8'h55);
      send_request(fhpa_pkg::FUNC_ALLOC, 8'h00);
      send_request(fhpa_pkg::FUNC_FREE,  8'h00);
      send_request(fhpa_pkg::FUNC_FREE,  8'h02);
      send_request(fhpa_pkg::FUNC_ALLOC, 8'h00);
      send_request(fhpa_pkg::FUNC_TRY,   8'hff);
      send_request(fhpa_pkg::FUNC_TRY,   8'h00);
      send_request(FUNC_UNUSED,          8'hff);
      send_request(fhpa_pkg::FUNC_FREE,  8'h03);

      for (int i = 0; i < RANDOM_ITEMS; i++) send_random(i);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.fails == 0) begin
         $display("[fifo_handle_pool_allocator_top] OK");
      end else begin
         $display("[fifo_handle_pool_allocator_top] ERROR");
      end
      $finish;
   end

   // Receiver: random stall per result, one long hold to back up the request side.
   initial begin : receiver
      int  gap;
      bit  held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(result_count + 40);
         if (!held && result_count == HOLD_AT) begin
            gap  = HOLD_CYCLES;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_data);
         result_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("[fifo_handle_pool_allocator_top] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
